[rtl/jssl_pkg.sv]
// Package with the shared types and constants of the joint-space step limiter.
`timescale 1ns / 1ps
package jssl_pkg;

    localparam int JOINT_W  = 32;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 64;
    localparam int RATIO_W  = 30;
    localparam int RATIO_BITS = 29;
    localparam int STEP_W   = 33;
    localparam int ROOT_W   = 36;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int DVD_W    = 62;
    localparam int DVS_W    = 36;
    localparam int ELAPSED_W = 16;
    localparam int SF_W     = 17;
    localparam int MS_W     = 32;
    localparam int P1_W     = ELAPSED_W + SF_W;
    localparam int P2_W     = P1_W + MS_W;
    localparam int CFG_W    = 32;

    // Tolerance of 0.001 rad and reset angle of joint 3 (-0.0698 rad) in Q3.28.
    localparam logic [MAG_W-1:0]   TOL      = MAG_W'(268435);
    localparam logic [JOINT_W-1:0] RESET_J3 = JOINT_W'(-18736795);
    localparam logic [SF_W-1:0]    SF_ONE   = SF_W'(65536);
    localparam logic [MS_W-1:0]    MS_RESET = MS_W'(16777216);
    localparam logic [STEP_W-1:0]  STEP_MAX = {STEP_W{1'b1}};

    // 4096000000 = 2^18 * 15625. The power of two is a shift; the odd factor is a
    // multiplication by ceil(2^61 / 15625), which is exact for numerators below 2^47.
    localparam int STEP_SHIFT = 18;
    localparam int RCP_IN_W   = 48;
    localparam int RCP_HALF   = 24;
    localparam int RCP_ACC_W  = 2 * RCP_IN_W;
    localparam int RCP_SHIFT  = 61;
    localparam int RCP_Q_W    = RCP_ACC_W - RCP_SHIFT;
    localparam logic [RCP_IN_W-1:0] STEP_RCP = 48'd147573952589677;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic REG_SPEED_FRAC = 1'b0;
    localparam logic REG_MAX_SPEED  = 1'b1;

    typedef struct packed {
        logic load;
        logic sq_en;
        logic snap;
        logic mul_en;
        logic upd_en;
    } lane_ctrl_t;

endpackage

[rtl/jssl_lane.sv]
// One joint lane: position and target storage, difference, square and step update.
`timescale 1ns / 1ps
module jssl_lane
    import jssl_pkg::*;
#(
    parameter int LANE_IDX = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lane_ctrl_t          ctrl,
    input  logic [JOINT_W-1:0]  tgt_in,
    input  logic [RATIO_W-1:0]  ratio,
    output logic [JOINT_W-1:0]  pos_out,
    output logic [SQ_W-1:0]     sq_out,
    output logic                in_tol
);

    localparam logic [JOINT_W-1:0] POS_RESET = (LANE_IDX == 3) ? RESET_J3 : '0;

    logic [JOINT_W-1:0] pos_reg, tgt_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [STEP_W-1:0]  delta_reg;
    logic signed [JOINT_W:0] diff;
    logic [JOINT_W:0]   diff_neg;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W+RATIO_W-1:0] prod;
    logic [JOINT_W-1:0] pos_next;

    always_comb begin
        diff     = $signed({tgt_reg[JOINT_W-1], tgt_reg}) - $signed({pos_reg[JOINT_W-1], pos_reg});
        diff_neg = -diff;
        mag      = diff[JOINT_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
        in_tol   = (mag < TOL);
        prod     = mag * ratio;
        if (diff[JOINT_W]) begin
            pos_next = pos_reg - delta_reg[JOINT_W-1:0];
        end else begin
            pos_next = pos_reg + delta_reg[JOINT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_RESET;
            tgt_reg <= POS_RESET;
        end else begin
            if (ctrl.load) begin
                tgt_reg <= tgt_in;
            end
            if (ctrl.snap) begin
                pos_reg <= tgt_reg;
            end else if (ctrl.upd_en) begin
                pos_reg <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.sq_en) begin
            sq_reg <= mag * mag;
        end
        if (ctrl.mul_en) begin
            delta_reg <= prod[RATIO_BITS +: STEP_W];
        end
    end

    assign pos_out = pos_reg;
    assign sq_out  = sq_reg;

endmodule

[rtl/jssl_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jssl_div
    import jssl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic [DVD_W-1:0]  quotient,
    output logic              done
);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   rem_sh, rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DVD_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend register shifts out at the top and collects quotient bits at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_reg <= rem_sub[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[rtl/jssl_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module jssl_sqrt
    import jssl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg, done_reg;
    logic [REM_W-1:0]  rem_sh, trial;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(ROOT_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[rtl/joint_space_step_limiter.sv]
// Joint-space step limiter: one lane per joint, a sequencer, a shared divider and a square root.
// A load beat (tuser 0) stores a new target and its result is offered from the done state
// once the output is free; a tick beat (tuser 1) moves the position at most elapsed_us x speed
// fraction x max_speed toward the target. A tick that moves along the difference vector runs
// through the step computation, the square sum, the square root, the divider and the position
// update; a tick that snaps to the target or finds zero distance ends after the square root, and
// a tick with every joint already within 0.001 rad goes straight to the done state. The tick work
// is done by the bit-serial square root of the summed squares, the bit-serial divider for
// step/distance, the reciprocal multiply for the step and a merge of the squares at one joint per cycle.
// One beat is worked on at a time, and the input is not ready again until the sequencer is back
// in idle; a new beat is taken while the previous result still waits on the master side, and a
// finished beat waits until that result has been taken.
`timescale 1ns / 1ps
module joint_space_step_limiter
    import jssl_pkg::*;
#(
    parameter int JOINT_COUNT = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [CFG_W-1:0]                 cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // target_j0 .. target_j(N-1), then elapsed_us
    input  logic [JOINT_COUNT*32+ELAPSED_W-1:0] s_tdata,
    // mode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // position_j0 .. position_j(N-1)
    output logic [JOINT_COUNT*32-1:0]        m_tdata,
    // arrived
    output logic                             m_tuser
);

    localparam int SUM_W = SQ_W + ((JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 0);
    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL1      = 4'd1;
    localparam logic [3:0] ST_MUL2      = 4'd2;
    localparam logic [3:0] ST_RCP       = 4'd3;
    localparam logic [3:0] ST_STEP      = 4'd4;
    localparam logic [3:0] ST_SUM       = 4'd5;
    localparam logic [3:0] ST_SQRT_GO   = 4'd6;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd7;
    localparam logic [3:0] ST_CMP       = 4'd8;
    localparam logic [3:0] ST_DIVR_GO   = 4'd9;
    localparam logic [3:0] ST_DIVR_WAIT = 4'd10;
    localparam logic [3:0] ST_MULQ      = 4'd11;
    localparam logic [3:0] ST_UPD       = 4'd12;
    localparam logic [3:0] ST_DONE      = 4'd13;

    logic [3:0]            state_reg, state_next;
    logic [SF_W-1:0]       sf_reg;
    logic [MS_W-1:0]       ms_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [P1_W-1:0]       p1_reg;
    logic [P2_W-1:0]       p2_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [RATIO_W-1:0]    ratio_reg;
    logic [1:0]            rcp_cnt_reg;
    logic [RCP_ACC_W-1:0]  rcp_acc_reg;
    logic                  m_tvalid_reg;
    logic [JOINT_COUNT*32-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    logic [JOINT_W-1:0]    pos_arr [JOINT_COUNT];
    logic [SQ_W-1:0]       sq_arr  [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] within_vec;
    logic                  all_within;
    lane_ctrl_t            ctrl;
    logic                  accept, out_free;
    logic [SF_W-1:0]       sf_clamped;
    logic                  div_start, div_done, sqrt_done;
    logic [DVD_W-1:0]      div_dvd, div_q;
    logic [DVS_W-1:0]      div_dvs;
    logic [ROOT_W-1:0]     root;
    logic                  snap_now;
    logic [RCP_IN_W-1:0]   rcp_in;
    logic [RCP_HALF-1:0]   rcp_a, rcp_b;
    logic [2*RCP_HALF-1:0] rcp_pp;
    logic [RCP_ACC_W-1:0]  rcp_term;
    logic [RCP_Q_W-1:0]    rcp_q;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign all_within = &within_vec;
    assign sf_clamped = (sf_reg > SF_ONE) ? SF_ONE : sf_reg;
    assign snap_now   = (state_reg == ST_CMP) && ({3'b000, step_reg} > root);

    always_comb begin
        ctrl        = '0;
        ctrl.load   = accept && (s_tuser == MODE_LOAD);
        ctrl.sq_en  = (state_reg == ST_MUL1);
        ctrl.snap   = snap_now;
        ctrl.mul_en = (state_reg == ST_MULQ);
        ctrl.upd_en = (state_reg == ST_UPD);
    end

    genvar g;
    generate
        for (g = 0; g < JOINT_COUNT; g++) begin : g_lane
            jssl_lane #(
                .LANE_IDX(g)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .tgt_in  (s_tdata[g*32 +: 32]),
                .ratio   (ratio_reg),
                .pos_out (pos_arr[g]),
                .sq_out  (sq_arr[g]),
                .in_tol  (within_vec[g])
            );
        end
    endgenerate

    // The step numerator times the reciprocal, one 24 x 24 partial product per cycle.
    always_comb begin
        rcp_in = RCP_IN_W'(p2_reg >> STEP_SHIFT);
        rcp_a  = rcp_cnt_reg[1] ? rcp_in[RCP_IN_W-1 -: RCP_HALF] : rcp_in[RCP_HALF-1:0];
        rcp_b  = rcp_cnt_reg[0] ? STEP_RCP[RCP_IN_W-1 -: RCP_HALF] : STEP_RCP[RCP_HALF-1:0];
        rcp_pp = rcp_a * rcp_b;
        case (rcp_cnt_reg)
            2'd0:    rcp_term = RCP_ACC_W'(rcp_pp);
            2'd3:    rcp_term = RCP_ACC_W'(rcp_pp) << (2 * RCP_HALF);
            default: rcp_term = RCP_ACC_W'(rcp_pp) << RCP_HALF;
        endcase
        rcp_q = rcp_acc_reg[RCP_ACC_W-1:RCP_SHIFT];
    end

    assign div_start = (state_reg == ST_DIVR_GO);
    assign div_dvd   = {step_reg, {RATIO_BITS{1'b0}}};
    assign div_dvs   = root;

    jssl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    jssl_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_SQRT_GO),
        .radicand (RAD_W'(acc_reg)),
        .root     (root),
        .done     (sqrt_done)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == MODE_LOAD || all_within) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_RCP;
            ST_RCP:       if (rcp_cnt_reg == 2'd3) state_next = ST_STEP;
            ST_STEP:      state_next = ST_SUM;
            ST_SUM: begin
                if (idx_reg == IDX_W'(JOINT_COUNT - 1)) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (sqrt_done) state_next = ST_CMP;
            ST_CMP: begin
                if (snap_now || root == '0) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIVR_GO;
                end
            end
            ST_DIVR_GO:   state_next = ST_DIVR_WAIT;
            ST_DIVR_WAIT: if (div_done) state_next = ST_MULQ;
            ST_MULQ:      state_next = ST_UPD;
            ST_UPD:       state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sf_reg       <= '0;
            ms_reg       <= MS_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_addr == REG_SPEED_FRAC) begin
                    sf_reg <= cfg_wdata[SF_W-1:0];
                end else begin
                    ms_reg <= cfg_wdata[MS_W-1:0];
                end
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the sequencer; the square sum is merged one lane per cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            elapsed_reg <= s_tdata[JOINT_COUNT*32 +: ELAPSED_W];
        end
        if (state_reg == ST_MUL1) begin
            p1_reg  <= elapsed_reg * sf_clamped;
            acc_reg <= '0;
            idx_reg <= '0;
        end
        if (state_reg == ST_MUL2) begin
            p2_reg      <= p1_reg * ms_reg;
            rcp_acc_reg <= '0;
            rcp_cnt_reg <= '0;
        end
        if (state_reg == ST_RCP) begin
            rcp_acc_reg <= rcp_acc_reg + rcp_term;
            rcp_cnt_reg <= rcp_cnt_reg + 2'd1;
        end
        if (state_reg == ST_STEP) begin
            step_reg <= (rcp_q > RCP_Q_W'(STEP_MAX)) ? STEP_MAX : rcp_q[STEP_W-1:0];
        end
        if (state_reg == ST_SUM) begin
            acc_reg <= acc_reg + SUM_W'(sq_arr[idx_reg]);
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (state_reg == ST_DIVR_WAIT && div_done) begin
            ratio_reg <= div_q[RATIO_W-1:0];
        end
        if (state_reg == ST_DONE && out_free) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                m_tdata_reg[j*32 +: 32] <= pos_arr[j];
            end
            m_tuser_reg <= all_within;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/jssl_check.sv]
// Port-level checker for the joint-space step limiter, bound to the top level.
`timescale 1ns / 1ps
module jssl_check #(
    parameter int JOINT_COUNT = 7
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [JOINT_COUNT*32-1:0]        m_tdata,
    input logic                             m_tuser
);

    // Nothing is offered on the master side right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    // Only one beat is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a beat is in work");

    // A result beat never appears without a beat having been taken before it.
    a_result_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result beat without work behind it");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind joint_space_step_limiter jssl_check #(.JOINT_COUNT(JOINT_COUNT)) u_jssl_check (.*);
